// ===== sv/urtb_pkg.sv =====
package urtb_pkg;

    localparam int RX_DEPTH = 64;
    localparam int TX_DEPTH = 64;
    localparam int RX_PTR_W = $clog2(RX_DEPTH);
    localparam int TX_PTR_W = $clog2(TX_DEPTH);
    localparam int RX_COUNT_W = 6;
    // wide enough for wptr + depth - rptr and for the count field
    localparam int RX_CALC_W = (RX_PTR_W + 1 > RX_COUNT_W) ? RX_PTR_W + 1 : RX_COUNT_W;

    localparam logic [2:0] OP_RX_BYTE   = 3'd0;
    localparam logic [2:0] OP_HOST_READ = 3'd1;
    localparam logic [2:0] OP_HOST_WRITE = 3'd2;
    localparam logic [2:0] OP_TX_READY  = 3'd3;
    localparam logic [2:0] OP_RX_FLUSH  = 3'd4;

    localparam logic [2:0] ERR_NONE         = 3'd0;
    localparam logic [2:0] ERR_BUF_OVERFLOW = 3'd4;

    typedef struct packed {
        logic [2:0] op;
        logic [7:0] data;
        logic       frame_error;
        logic       data_overrun;
    } item_t;

    typedef struct packed {
        logic                  read_valid;
        logic [7:0]            read_byte;
        logic [2:0]            read_error;
        logic                  write_accepted;
        logic                  send_valid;
        logic [7:0]            send_byte;
        logic                  send_irq_enabled;
        logic [RX_COUNT_W-1:0] rx_count;
    } result_t;

    typedef struct packed {
        logic load;
        logic exec;
    } ctl_cmd_t;

    function automatic logic [RX_PTR_W-1:0] rx_next(input logic [RX_PTR_W-1:0] p);
        return (p == RX_PTR_W'(RX_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    function automatic logic [TX_PTR_W-1:0] tx_next(input logic [TX_PTR_W-1:0] p);
        return (p == TX_PTR_W'(TX_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

endpackage

// ===== sv/urtb_ctrl.sv =====
module urtb_ctrl
    import urtb_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     start,
    output logic     busy,
    output logic     done,
    output ctl_cmd_t cmd
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_RESP
    } state_t;

    state_t state_reg;
    logic   busy_reg;
    logic   done_reg;

    assign busy     = busy_reg;
    assign done     = done_reg;
    assign cmd.load = start && !busy_reg;
    assign cmd.exec = (state_reg == ST_EXEC);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            unique case (state_reg)
                ST_IDLE:
                begin
                    done_reg <= 1'b0;
                    if (start)
                    begin
                        state_reg <= ST_EXEC;
                        busy_reg  <= 1'b1;
                    end
                end
                ST_EXEC:
                begin
                    state_reg <= ST_RESP;
                    done_reg  <= 1'b1;
                end
                ST_RESP:
                begin
                    state_reg <= ST_IDLE;
                    busy_reg  <= 1'b0;
                    done_reg  <= 1'b0;
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                    busy_reg  <= 1'b0;
                    done_reg  <= 1'b0;
                end
            endcase
        end
    end

endmodule

// ===== sv/urtb_datapath.sv =====
module urtb_datapath
    import urtb_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  ctl_cmd_t cmd,
    input  item_t    request,
    output result_t  result
);

    logic [7:0] rx_mem [RX_DEPTH];
    logic [7:0] tx_mem [TX_DEPTH];

    item_t item_reg;

    logic [RX_PTR_W-1:0] rx_wp_reg, rx_wp_next;
    logic [RX_PTR_W-1:0] rx_rp_reg, rx_rp_next;
    logic [TX_PTR_W-1:0] tx_wp_reg, tx_wp_next;
    logic [TX_PTR_W-1:0] tx_rp_reg, tx_rp_next;
    logic [2:0]          last_err_reg, last_err_next;
    logic                irq_reg, irq_next;

    logic                  read_valid_reg, read_valid_next;
    logic [2:0]            read_error_reg, read_error_next;
    logic                  write_acc_reg, write_acc_next;
    logic                  send_valid_reg, send_valid_next;
    logic [RX_COUNT_W-1:0] count_reg, count_next;
    logic [7:0]            rx_rdata_reg;
    logic [7:0]            tx_rdata_reg;

    logic [RX_PTR_W-1:0]  rx_wp_inc;
    logic [RX_PTR_W-1:0]  rx_rp_inc;
    logic [TX_PTR_W-1:0]  tx_wp_inc;
    logic [TX_PTR_W-1:0]  tx_rp_inc;
    logic [2:0]           line_err;
    logic [RX_CALC_W-1:0] count_calc;

    always_comb
    begin
        rx_wp_inc = rx_next(rx_wp_reg);
        rx_rp_inc = rx_next(rx_rp_reg);
        tx_wp_inc = tx_next(tx_wp_reg);
        tx_rp_inc = tx_next(tx_rp_reg);
        line_err  = {1'b0, item_reg.frame_error, item_reg.data_overrun};

        rx_wp_next      = rx_wp_reg;
        rx_rp_next      = rx_rp_reg;
        tx_wp_next      = tx_wp_reg;
        tx_rp_next      = tx_rp_reg;
        last_err_next   = last_err_reg;
        irq_next        = irq_reg;
        read_valid_next = 1'b0;
        read_error_next = ERR_NONE;
        write_acc_next  = 1'b0;
        send_valid_next = 1'b0;

        unique case (item_reg.op)
            OP_RX_BYTE:
            begin
                rx_wp_next = rx_wp_inc;
                // full ring: the oldest byte is dropped
                if (rx_wp_inc == rx_rp_reg)
                begin
                    rx_rp_next    = rx_rp_inc;
                    last_err_next = ERR_BUF_OVERFLOW;
                end
                else
                begin
                    last_err_next = line_err;
                end
            end
            OP_HOST_READ:
            begin
                if (rx_wp_reg != rx_rp_reg)
                begin
                    read_valid_next = 1'b1;
                    read_error_next = last_err_reg;
                    rx_rp_next      = rx_rp_inc;
                end
            end
            OP_HOST_WRITE:
            begin
                if (tx_wp_inc != tx_rp_reg)
                begin
                    tx_wp_next     = tx_wp_inc;
                    irq_next       = 1'b1;
                    write_acc_next = 1'b1;
                end
            end
            OP_TX_READY:
            begin
                if (tx_wp_reg != tx_rp_reg)
                begin
                    send_valid_next = 1'b1;
                    tx_rp_next      = tx_rp_inc;
                end
                else
                begin
                    irq_next = 1'b0;
                end
            end
            OP_RX_FLUSH:
            begin
                rx_wp_next = rx_rp_reg;
            end
            default:
            begin
            end
        endcase

        if (rx_wp_next >= rx_rp_next)
            count_calc = RX_CALC_W'(rx_wp_next) - RX_CALC_W'(rx_rp_next);
        else
            count_calc = RX_CALC_W'(rx_wp_next) + RX_CALC_W'(RX_DEPTH)
                       - RX_CALC_W'(rx_rp_next);
        count_next = count_calc[RX_COUNT_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rx_wp_reg    <= '0;
            rx_rp_reg    <= '0;
            tx_wp_reg    <= '0;
            tx_rp_reg    <= '0;
            last_err_reg <= ERR_NONE;
            irq_reg      <= 1'b0;
        end
        else if (cmd.exec)
        begin
            rx_wp_reg    <= rx_wp_next;
            rx_rp_reg    <= rx_rp_next;
            tx_wp_reg    <= tx_wp_next;
            tx_rp_reg    <= tx_rp_next;
            last_err_reg <= last_err_next;
            irq_reg      <= irq_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
            item_reg <= request;
        if (cmd.exec)
        begin
            read_valid_reg <= read_valid_next;
            read_error_reg <= read_error_next;
            write_acc_reg  <= write_acc_next;
            send_valid_reg <= send_valid_next;
            count_reg      <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.exec)
        begin
            if (item_reg.op == OP_RX_BYTE)
                rx_mem[rx_wp_reg] <= item_reg.data;
            if (item_reg.op == OP_HOST_WRITE && tx_wp_inc != tx_rp_reg)
                tx_mem[tx_wp_reg] <= item_reg.data;
            rx_rdata_reg <= rx_mem[rx_rp_reg];
            tx_rdata_reg <= tx_mem[tx_rp_reg];
        end
    end

    assign result.read_valid       = read_valid_reg;
    assign result.read_byte        = read_valid_reg ? rx_rdata_reg : 8'd0;
    assign result.read_error       = read_error_reg;
    assign result.write_accepted   = write_acc_reg;
    assign result.send_valid       = send_valid_reg;
    assign result.send_byte        = send_valid_reg ? tx_rdata_reg : 8'd0;
    assign result.send_irq_enabled = irq_reg;
    assign result.rx_count         = count_reg;

endmodule

// ===== sv/uart_rx_tx_ring_buffer_core.sv =====
// Buffered UART front end: a receive ring and a transmit ring, both 64 bytes
// (one slot kept free, so 63 usable), driven by one event per transfer.
// Input channel: request (op, data, frame_error, data_overrun) is taken at a
// rising edge with start high and busy low. Ops: byte received, host read,
// host write, transmitter ready, flush receive ring; other codes only report.
// Output channel: one result per event, valid on result while done is high for
// exactly one cycle. The receiver cannot stall, so a result is never held.
// Timing: the request is registered on acceptance (ST_IDLE to ST_EXEC); busy
// stays high through ST_EXEC and ST_RESP, so a new request is taken only after
// the event is through. In ST_EXEC the event updates the pointers and reads the
// ring through its registered read port; the byte shows up the next cycle, with done.
// Reset clears all pointers, the saved receive error and the transmit
// interrupt enable; ring contents are not cleared and need no clearing pass.
module uart_rx_tx_ring_buffer_core
    import urtb_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    start,
    output logic    busy,
    input  item_t   request,
    output logic    done,
    output result_t result
);

    ctl_cmd_t cmd;

    urtb_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .done  (done),
        .cmd   (cmd)
    );

    urtb_datapath u_datapath (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (cmd),
        .request (request),
        .result  (result)
    );

    a_accept_done: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |-> ##2 done)
        else $error("result not delivered two cycles after transfer");

    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result strobe longer than one cycle");

    a_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> busy)
        else $error("result strobe while idle");

    // a nonempty transmit ring always has the interrupt enabled
    a_send_irq: assert property (@(posedge clk) disable iff (!rst_n)
        done && result.send_valid |-> result.send_irq_enabled)
        else $error("byte sent with transmit interrupt disabled");

endmodule

// ===== tb/uart_rx_tx_ring_buffer_core_test.sv =====
module uart_rx_tx_ring_buffer_core_test;
    import urtb_pkg::*;

    localparam logic [2:0] ERR_LINE_OVERRUN = 3'd1;
    localparam logic [2:0] ERR_LINE_FRAMING = 3'd2;
    localparam logic [2:0] OP_SPARE_FIRST   = 3'd5;
    localparam logic [2:0] OP_SPARE_LAST    = 3'd7;
    localparam int         SETTLE_CYCLES    = 10;
    localparam int         DRAIN_LIMIT      = 2000;

    logic    clk;
    logic    rst_n;
    logic    start;
    logic    busy;
    logic    done;
    item_t   request;
    result_t result;

    uart_rx_tx_ring_buffer_core u_top (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .busy    (busy),
        .request (request),
        .done    (done),
        .result  (result)
    );

    // shadow copy of both rings
    logic [7:0] rx_mem [RX_DEPTH];
    logic [7:0] tx_mem [TX_DEPTH];
    int         rx_wr;
    int         rx_rd;
    int         tx_wr;
    int         tx_rd;
    logic [2:0] rx_last_err;
    logic       tx_irq;

    result_t pending_results[$];
    result_t want;
    int      errors;
    int      n_checked;
    int      n_overflow;
    int      n_rejected;
    int      n_spare;
    int      burst_left;
    int      op_hits [8];

    logic [2:0] lane_ops [4] = '{OP_RX_BYTE, OP_HOST_READ, OP_HOST_WRITE, OP_TX_READY};

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // advance the shadow rings by one event and return what the block must report
    function automatic result_t apply_event(input item_t ev);
        result_t    r;
        logic [2:0] err;
        r = '0;
        case (ev.op)
            OP_RX_BYTE:
            begin
                err = (ev.data_overrun ? ERR_LINE_OVERRUN : ERR_NONE)
                    | (ev.frame_error ? ERR_LINE_FRAMING : ERR_NONE);
                rx_mem[rx_wr] = ev.data;
                rx_wr = (rx_wr + 1) % RX_DEPTH;
                if (rx_wr == rx_rd)
                begin
                    // ring was full: oldest byte is lost
                    err = ERR_BUF_OVERFLOW;
                    rx_rd = (rx_rd + 1) % RX_DEPTH;
                    n_overflow++;
                end
                rx_last_err = err;
            end
            OP_HOST_READ:
            begin
                if (rx_wr != rx_rd)
                begin
                    r.read_valid = 1'b1;
                    r.read_byte  = rx_mem[rx_rd];
                    r.read_error = rx_last_err;
                    rx_rd = (rx_rd + 1) % RX_DEPTH;
                end
            end
            OP_HOST_WRITE:
            begin
                if ((tx_wr + 1) % TX_DEPTH != tx_rd)
                begin
                    tx_mem[tx_wr] = ev.data;
                    tx_wr = (tx_wr + 1) % TX_DEPTH;
                    tx_irq = 1'b1;
                    r.write_accepted = 1'b1;
                end
                else
                begin
                    n_rejected++;
                end
            end
            OP_TX_READY:
            begin
                if (tx_wr != tx_rd)
                begin
                    r.send_valid = 1'b1;
                    r.send_byte  = tx_mem[tx_rd];
                    tx_rd = (tx_rd + 1) % TX_DEPTH;
                end
                else
                begin
                    tx_irq = 1'b0;
                end
            end
            OP_RX_FLUSH:
            begin
                rx_wr = rx_rd;
            end
            default:
            begin
            end
        endcase
        r.send_irq_enabled = tx_irq;
        r.rx_count = RX_COUNT_W'((rx_wr + RX_DEPTH - rx_rd) % RX_DEPTH);
        return r;
    endfunction

    function automatic item_t make_event(input logic [2:0] op, input logic [7:0] data,
                                         input logic fe, input logic dor);
        item_t ev;
        ev.op           = op;
        ev.data         = data;
        ev.frame_error  = fe;
        ev.data_overrun = dor;
        return ev;
    endfunction

    function automatic item_t random_event(input logic [2:0] op);
        return make_event(op, 8'($urandom_range(0, 255)), 1'($urandom), 1'($urandom));
    endfunction

    // mode 0 spreads ops evenly, modes 1..4 lean on one lane to push the rings to their ends
    function automatic logic [2:0] pick_op(input int mode);
        int r;
        r = $urandom_range(0, 99);
        if (r < 2)
            return OP_RX_FLUSH;
        if (r < 4)
            return 3'($urandom_range(OP_SPARE_FIRST, OP_SPARE_LAST));
        r = $urandom_range(0, 99);
        if (mode == 0)
            return lane_ops[r % 4];
        if (r < 70)
            return lane_ops[mode - 1];
        return lane_ops[$urandom_range(0, 3)];
    endfunction

    task automatic check_field(input string name, input logic [7:0] exp_v,
                               input logic [7:0] act_v);
        if (exp_v !== act_v)
        begin
            errors++;
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, act_v);
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (pending_results.size() == 0)
            begin
                errors++;
                $display("%0t: result with nothing expected, expected none, actual %h",
                         $time, result);
            end
            else
            begin
                want = pending_results.pop_front();
                check_field("read_valid", want.read_valid, result.read_valid);
                check_field("read_byte", want.read_byte, result.read_byte);
                check_field("read_error", want.read_error, result.read_error);
                check_field("write_accepted", want.write_accepted, result.write_accepted);
                check_field("send_valid", want.send_valid, result.send_valid);
                check_field("send_byte", want.send_byte, result.send_byte);
                check_field("send_irq_enabled", want.send_irq_enabled,
                            result.send_irq_enabled);
                check_field("rx_count", want.rx_count, result.rx_count);
                n_checked++;
            end
        end
    end

    // one transfer: start stays high until an edge sees busy low
    task automatic send_event(input item_t ev);
        @(negedge clk);
        start   <= 1'b1;
        request <= ev;
        do
            @(posedge clk);
        while (busy);
        pending_results.push_back(apply_event(ev));
        op_hits[ev.op]++;
    endtask

    task automatic hold_off(input int cycles);
        repeat (cycles)
        begin
            @(negedge clk);
            start <= 1'b0;
        end
    endtask

    task automatic paced_send(input item_t ev);
        send_event(ev);
        burst_left--;
        if (burst_left <= 0)
        begin
            hold_off(($urandom_range(0, 7) == 0) ? $urandom_range(8, 20) : $urandom_range(1, 5));
            burst_left = $urandom_range(1, 24);
        end
    endtask

    task automatic wait_quiet();
        hold_off(1);
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic test_empty_rings();
        send_event(make_event(OP_HOST_READ, 8'hFF, 1'b1, 1'b1));
        send_event(make_event(OP_TX_READY, 8'h00, 1'b0, 1'b0));
        send_event(make_event(OP_RX_FLUSH, 8'hA5, 1'b1, 1'b0));
        for (int op = OP_SPARE_FIRST; op <= OP_SPARE_LAST; op++)
            send_event(random_event(3'(op)));
    endtask

    task automatic test_line_errors();
        send_event(make_event(OP_RX_BYTE, 8'h00, 1'b0, 1'b0));
        send_event(make_event(OP_RX_BYTE, 8'hFF, 1'b1, 1'b1));
        send_event(make_event(OP_HOST_READ, 8'h00, 1'b0, 1'b0));
        send_event(make_event(OP_RX_BYTE, 8'h5A, 1'b1, 1'b0));
        send_event(make_event(OP_RX_BYTE, 8'hA5, 1'b0, 1'b1));
        repeat (4)
            send_event(make_event(OP_HOST_READ, 8'h00, 1'b0, 1'b0));
    endtask

    task automatic test_tx_path();
        send_event(make_event(OP_HOST_WRITE, 8'h00, 1'b1, 1'b1));
        send_event(make_event(OP_HOST_WRITE, 8'hFF, 1'b0, 1'b0));
        repeat (3)
            send_event(make_event(OP_TX_READY, 8'h00, 1'b0, 1'b0));
    endtask

    task automatic test_rx_overflow();
        repeat (RX_DEPTH + 2)
            paced_send(random_event(OP_RX_BYTE));
        repeat (3)
            paced_send(random_event(OP_HOST_READ));
        paced_send(random_event(OP_RX_FLUSH));
        paced_send(random_event(OP_HOST_READ));
    endtask

    task automatic test_tx_full();
        repeat (TX_DEPTH + 1)
            paced_send(random_event(OP_HOST_WRITE));
        repeat (TX_DEPTH + 1)
            paced_send(random_event(OP_TX_READY));
    endtask

    task automatic test_random_traffic(input int count);
        int mode;
        int phase_left;
        phase_left = 0;
        mode = 0;
        for (int i = 0; i < count; i++)
        begin
            if (phase_left == 0)
            begin
                mode = $urandom_range(0, 4);
                phase_left = $urandom_range(20, 90);
            end
            phase_left--;
            paced_send(random_event(pick_op(mode)));
        end
    endtask

    initial
    begin
        rst_n       = 1'b0;
        start       = 1'b0;
        request     = '0;
        rx_wr       = 0;
        rx_rd       = 0;
        tx_wr       = 0;
        tx_rd       = 0;
        rx_last_err = ERR_NONE;
        tx_irq      = 1'b0;
        errors      = 0;
        n_checked   = 0;
        n_overflow  = 0;
        n_rejected  = 0;
        n_spare     = 0;
        burst_left  = 1;
        foreach (op_hits[i])
            op_hits[i] = 0;
        repeat (3)
            @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_empty_rings();
        test_line_errors();
        test_tx_path();
        wait_quiet();
        test_rx_overflow();
        test_tx_full();
        wait_quiet();
        test_random_traffic(900);

        hold_off(1);
        for (int i = 0; i < DRAIN_LIMIT && pending_results.size() != 0; i++)
            @(posedge clk);
        repeat (SETTLE_CYCLES)
            @(posedge clk);
        if (pending_results.size() != 0)
        begin
            errors++;
            $display("%0t: results missing, expected %0d more, actual 0", $time,
                     pending_results.size());
        end

        for (int op = OP_SPARE_FIRST; op <= OP_SPARE_LAST; op++)
            n_spare += op_hits[op];
        $display(
            "Checked %0d: %0d rx, %0d reads, %0d writes, %0d tx ready, %0d flush, %0d unused op",
            n_checked, op_hits[OP_RX_BYTE], op_hits[OP_HOST_READ],
            op_hits[OP_HOST_WRITE], op_hits[OP_TX_READY], op_hits[OP_RX_FLUSH], n_spare);
        $display("Receive overflows %0d, rejected writes %0d", n_overflow, n_rejected);
        if (errors == 0)
            $display("uart_rx_tx_ring_buffer_core verification clean");
        else
            $display("uart_rx_tx_ring_buffer_core verification failed");
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("uart_rx_tx_ring_buffer_core verification failed");
        $finish;
    end

endmodule
